// ===== sv/assert_macros.svh =====
// Assertion helpers used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== sv/lmts_pkg.sv =====
package lmts_pkg;

   localparam int ALU_W        = 7;
   localparam int COL_ADDR_W   = 6;
   localparam int STEP_W       = 6;
   localparam int GLYPH_W      = 6;
   localparam int FIRST_CODE   = 32;
   localparam int LAST_CODE    = 125;
   localparam int WPOS_MAX     = 63;
   localparam int FONT_DEPTH   = LAST_CODE - FIRST_CODE + 1;
   localparam logic [5:0] ACTIVE_RESET = 6'd32;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_PUT    = 2'd1,
      CMD_SCROLL = 2'd2,
      CMD_SCAN   = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PUT,
      ST_PUT_END,
      ST_SCR_START,
      ST_SCR_FIRST,
      ST_SCR_RD,
      ST_SCR_WR,
      ST_SCAN_ROW,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic [ALU_W-1:0] op_a;
      logic [ALU_W-1:0] op_b;
      logic [ALU_W-1:0] limit;
   } alu_req_type;

   typedef struct packed {
      logic [ALU_W-1:0] sum;
      logic             below;
   } alu_rsp_type;

   typedef struct packed {
      logic                  clear;
      logic                  wr_en;
      logic [COL_ADDR_W-1:0] wr_addr;
      logic [7:0]            wr_data;
      logic                  rd_en;
      logic [COL_ADDR_W-1:0] rd_addr;
   } mem_req_type;

   // 5 glyph columns per code, first column in the top byte; sixth column is blank
   localparam logic [39:0] FONT_ROM [0:FONT_DEPTH-1] = '{
      40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
      40'h24_2A_7F_2A_12, 40'h23_13_08_64_62, 40'h36_49_55_22_50, 40'h00_05_03_00_00,
      40'h00_1C_22_41_00, 40'h00_41_22_1C_00, 40'h14_08_3E_08_14, 40'h08_08_3E_08_08,
      40'h00_50_30_00_00, 40'h08_08_08_08_08, 40'h00_60_60_00_00, 40'h20_10_08_04_02,
      40'h3E_41_41_41_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31,
      40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
      40'h36_49_49_49_36, 40'h06_49_49_29_1E, 40'h00_36_36_00_00, 40'h00_56_36_00_00,
      40'h08_14_22_41_00, 40'h14_14_14_14_14, 40'h00_41_22_14_08, 40'h02_01_51_09_06,
      40'h32_49_79_41_3E, 40'h7E_09_09_09_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
      40'h7F_41_41_22_1C, 40'h7F_49_49_49_41, 40'h7F_09_09_09_01, 40'h3E_41_49_49_7A,
      40'h7F_08_08_08_7F, 40'h41_41_7F_41_41, 40'h20_40_40_40_3F, 40'h7F_08_14_22_41,
      40'h7F_40_40_40_40, 40'h7F_02_0C_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
      40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h46_49_49_49_31,
      40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h3F_40_38_40_3F,
      40'h63_14_08_14_63, 40'h07_08_70_08_07, 40'h61_51_49_45_43, 40'h00_7F_41_41_00,
      40'h02_04_08_10_20, 40'h00_41_41_7F_00, 40'h04_02_01_02_04, 40'h40_40_40_40_40,
      40'h00_01_02_04_00, 40'h20_54_54_54_78, 40'h7F_48_44_44_38, 40'h38_44_44_44_00,
      40'h38_44_44_48_7F, 40'h38_54_54_54_18, 40'h08_7E_09_01_02, 40'h08_14_54_54_3C,
      40'h7F_08_04_04_78, 40'h00_44_7D_40_00, 40'h20_40_44_3D_00, 40'h00_7F_10_28_44,
      40'h00_41_7F_40_00, 40'h7C_04_18_04_78, 40'h7C_08_04_04_78, 40'h38_44_44_44_38,
      40'h7C_14_14_14_08, 40'h08_14_14_18_7C, 40'h7C_08_04_04_08, 40'h48_54_54_54_20,
      40'h04_3F_44_40_20, 40'h3C_40_40_20_7C, 40'h1C_20_40_20_1C, 40'h3C_40_30_40_3C,
      40'h44_28_10_28_44, 40'h0C_50_50_50_3C, 40'h44_64_54_4C_44, 40'h00_08_36_41_00,
      40'h00_00_7F_00_00, 40'h00_41_36_08_00
   };

   function automatic logic [7:0] font_column(input logic [7:0] code, input logic [2:0] k);
      logic [6:0]  idx;
      logic [2:0]  sel;
      logic [39:0] word;
      logic [7:0]  col;
      idx  = 7'(code - 8'(FIRST_CODE));
      sel  = 3'd4 - k;
      word = 40'd0;
      col  = 8'd0;
      if (code >= 8'(FIRST_CODE) && code <= 8'(LAST_CODE) && k < 3'd5) begin
         word = FONT_ROM[idx] >> {sel, 3'b000};
         col  = word[7:0];
      end
      return col;
   endfunction

endpackage

// ===== sv/lmts_alu.sv =====
module lmts_alu
   import lmts_pkg::*;
(
   input  alu_req_type alu_req,
   output alu_rsp_type alu_rsp
);

   logic [ALU_W-1:0] sum;

   assign sum           = alu_req.op_a + alu_req.op_b;
   assign alu_rsp.sum   = sum;
   assign alu_rsp.below = (sum < alu_req.limit);

endmodule

// ===== sv/lmts_colmem.sv =====
module lmts_colmem
   import lmts_pkg::*;
#(
   parameter int NUM_COLUMNS = 32
)(
   input  logic        clock,
   input  logic        reset,
   input  mem_req_type mem_req,
   output logic [7:0]  rd_data
);

   localparam int AW = $clog2(NUM_COLUMNS);

   logic [7:0]             mem_ff [0:NUM_COLUMNS-1];
   logic [NUM_COLUMNS-1:0] valid_ff;
   logic [NUM_COLUMNS-1:0] valid_in;
   logic [7:0]             rd_data_ff;
   logic [AW-1:0]          wa;
   logic [AW-1:0]          ra;

   assign wa = mem_req.wr_addr[AW-1:0];
   assign ra = mem_req.rd_addr[AW-1:0];

   // unwritten columns read as blank
   always_comb begin
      valid_in = valid_ff;
      if (mem_req.clear) begin
         valid_in = '0;
      end else if (mem_req.wr_en) begin
         valid_in[wa] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[wa] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= valid_ff[ra] ? mem_ff[ra] : 8'd0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/lmts_seq.sv =====
`include "assert_macros.svh"

module lmts_seq
   import lmts_pkg::*;
#(
   parameter int NUM_COLUMNS = 32,
   parameter int NUM_ROWS    = 8
)(
   input  logic        clock,
   input  logic        reset,
   input  logic [5:0]  active,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_code,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_bit,
   output logic        rsp_last,
   output mem_req_type mem_req,
   input  logic [7:0]  mem_rd_data,
   output alu_req_type alu_req,
   input  alu_rsp_type alu_rsp
);

   localparam int TOTAL = NUM_COLUMNS + 8;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [7:0]        code_ff, code_in;
   logic [5:0]        wpos_ff, wpos_in;
   logic [2:0]        row_ff, row_in;
   logic [7:0]        first_ff, first_in;
   logic              s1_v_ff, s1_v_in;
   logic              s1_col_ff, s1_col_in;
   logic              s1_bit_ff, s1_bit_in;
   logic              s1_last_ff, s1_last_in;
   logic [2:0]        s1_row_ff, s1_row_in;
   logic              out_v_ff, out_v_in;
   logic              out_bit_ff, out_bit_in;
   logic              out_last_ff, out_last_in;
   logic              out_load;
   logic              s1_free;
   logic              issue;
   logic [STEP_W-1:0] row_idx;

   assign out_load  = s1_v_ff && (!out_v_ff || rsp_ready);
   assign s1_free   = !s1_v_ff || out_load;
   assign req_ready = (state_ff == ST_IDLE) && !s1_v_ff;
   assign row_idx   = step_ff - STEP_W'(NUM_COLUMNS);

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      code_in    = code_ff;
      wpos_in    = wpos_ff;
      row_in     = row_ff;
      first_in   = first_ff;
      issue      = 1'b0;
      s1_col_in  = s1_col_ff;
      s1_bit_in  = s1_bit_ff;
      s1_last_in = s1_last_ff;
      s1_row_in  = s1_row_ff;
      mem_req    = '0;
      alu_req    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               unique case (cmd_type'(req_cmd))
                  CMD_CLEAR: begin
                     mem_req.clear = 1'b1;
                     wpos_in       = 6'd0;
                  end
                  CMD_PUT: begin
                     code_in  = req_code;
                     step_in  = '0;
                     state_in = ST_PUT;
                  end
                  CMD_SCROLL: state_in = ST_SCR_START;
                  CMD_SCAN:   state_in = ST_SCAN_ROW;
               endcase
            end
         end
         ST_PUT: begin
            alu_req.op_a    = ALU_W'(wpos_ff);
            alu_req.op_b    = ALU_W'(step_ff);
            alu_req.limit   = ALU_W'(active);
            mem_req.wr_en   = alu_rsp.below;
            mem_req.wr_addr = alu_rsp.sum[COL_ADDR_W-1:0];
            mem_req.wr_data = font_column(code_ff, step_ff[2:0]);
            step_in         = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(GLYPH_W - 1)) begin
               state_in = ST_PUT_END;
            end
         end
         ST_PUT_END: begin
            alu_req.op_a  = ALU_W'(wpos_ff);
            alu_req.op_b  = ALU_W'(GLYPH_W);
            alu_req.limit = ALU_W'(WPOS_MAX + 1);
            wpos_in       = alu_rsp.below ? alu_rsp.sum[5:0] : 6'(WPOS_MAX);
            state_in      = ST_IDLE;
         end
         ST_SCR_START: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = '0;
            state_in        = ST_SCR_FIRST;
         end
         ST_SCR_FIRST: begin
            first_in = mem_rd_data;
            step_in  = '0;
            state_in = ST_SCR_RD;
         end
         ST_SCR_RD: begin
            alu_req.op_a  = ALU_W'(step_ff);
            alu_req.op_b  = ALU_W'(1);
            alu_req.limit = ALU_W'(active);
            if (alu_rsp.below) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = alu_rsp.sum[COL_ADDR_W-1:0];
               state_in        = ST_SCR_WR;
            end else begin
               // last active column takes the old first column
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = COL_ADDR_W'(step_ff);
               mem_req.wr_data = first_ff;
               state_in        = ST_IDLE;
            end
         end
         ST_SCR_WR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = COL_ADDR_W'(step_ff);
            mem_req.wr_data = mem_rd_data;
            step_in         = step_ff + STEP_W'(1);
            state_in        = ST_SCR_RD;
         end
         ST_SCAN_ROW: begin
            alu_req.op_a  = ALU_W'(row_ff);
            alu_req.op_b  = ALU_W'(1);
            alu_req.limit = ALU_W'(NUM_ROWS);
            row_in        = alu_rsp.below ? alu_rsp.sum[2:0] : 3'd0;
            step_in       = '0;
            state_in      = ST_SCAN;
         end
         ST_SCAN: begin
            alu_req.op_a  = ALU_W'(step_ff);
            alu_req.op_b  = ALU_W'(1);
            alu_req.limit = ALU_W'(TOTAL);
            if (s1_free) begin
               issue      = 1'b1;
               s1_row_in  = row_ff;
               s1_last_in = !alu_rsp.below;
               if (step_ff < STEP_W'(NUM_COLUMNS)) begin
                  // columns go out from the last one down
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = COL_ADDR_W'(NUM_COLUMNS - 1) - COL_ADDR_W'(step_ff);
                  s1_col_in       = 1'b1;
                  s1_bit_in       = 1'b0;
               end else begin
                  s1_col_in = 1'b0;
                  s1_bit_in = (row_idx[2:0] == row_ff);
               end
               step_in = alu_rsp.sum[STEP_W-1:0];
               if (!alu_rsp.below) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      s1_v_in = s1_v_ff;
      if (issue) begin
         s1_v_in = 1'b1;
      end else if (out_load) begin
         s1_v_in = 1'b0;
      end
      out_v_in    = out_v_ff;
      out_bit_in  = out_bit_ff;
      out_last_in = out_last_ff;
      if (out_load) begin
         out_v_in    = 1'b1;
         out_bit_in  = s1_col_ff ? mem_rd_data[s1_row_ff] : s1_bit_ff;
         out_last_in = s1_last_ff;
      end else if (rsp_ready) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wpos_ff  <= 6'd0;
         row_ff   <= 3'd0;
         s1_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wpos_ff  <= wpos_in;
         row_ff   <= row_in;
         s1_v_ff  <= s1_v_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      code_ff     <= code_in;
      first_ff    <= first_in;
      s1_col_ff   <= s1_col_in;
      s1_bit_ff   <= s1_bit_in;
      s1_last_ff  <= s1_last_in;
      s1_row_ff   <= s1_row_in;
      out_bit_ff  <= out_bit_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_bit   = out_bit_ff;
   assign rsp_last  = out_last_ff;

   `ASSERT_NEVER(a_rd_wr_excl, clock, reset, mem_req.wr_en && mem_req.rd_en,
      "column store read and written in one cycle")
   `ASSERT_CLK(a_wr_in_active, clock, reset, mem_req.wr_en |-> (6'(mem_req.wr_addr) < active),
      "column write beyond active width")
   `ASSERT_NEVER(a_row_range, clock, reset, 32'(row_ff) >= NUM_ROWS,
      "scan row out of range")
   `ASSERT_CLK(a_s1_hold, clock, reset, (s1_v_ff && !out_load) |=> s1_v_ff,
      "stalled scan item dropped")

endmodule

// ===== sv/led_matrix_text_scroll_scanner_top.sv =====
// channel  | ports                     | contents
// req      | req_tvalid/tready         | tdata: char_code[7:0]; tuser: cmd[1:0]
// rsp      | rsp_tvalid/tready         | tdata: serial_bit[0], zeros above; tlast: latch_last
// csr      | csr_wr_en, csr_wr_data    | active_columns[5:0]
// Scan reads one column a cycle from the column store, unless the output stalls.
// A new item is taken once the sequencer is idle and no scan bit waits in the read stage.
// Output stalls hold the scan at the read stage; synchronous reset blanks the store at once.
module led_matrix_text_scroll_scanner_top
   import lmts_pkg::*;
#(
   parameter int NUM_COLUMNS = 32,
   parameter int NUM_ROWS    = 8
)(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // char_code[7:0]
   input  logic [1:0] req_tuser,   // cmd[1:0]
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // serial_bit[0], zero fill [7:1]
   output logic       rsp_tlast,
   input  logic       csr_wr_en,
   input  logic [5:0] csr_wr_data
);

   logic [5:0]  active_ff, active_in;
   logic [5:0]  active_eff;
   logic        rsp_bit;
   mem_req_type mem_req;
   logic [7:0]  mem_rd_data;
   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   assign active_in = csr_wr_en ? csr_wr_data : active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
      end else begin
         active_ff <= active_in;
      end
   end

   always_comb begin
      active_eff = active_ff;
      if (active_ff == 6'd0) begin
         active_eff = 6'd1;
      end else if (active_ff > 6'(NUM_COLUMNS)) begin
         active_eff = 6'(NUM_COLUMNS);
      end
   end

   lmts_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   lmts_colmem #(
      .NUM_COLUMNS (NUM_COLUMNS)
   ) u_colmem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   lmts_seq #(
      .NUM_COLUMNS (NUM_COLUMNS),
      .NUM_ROWS    (NUM_ROWS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .active      (active_eff),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_cmd     (req_tuser),
      .req_code    (req_tdata),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_bit     (rsp_bit),
      .rsp_last    (rsp_tlast),
      .mem_req     (mem_req),
      .mem_rd_data (mem_rd_data),
      .alu_req     (alu_req),
      .alu_rsp     (alu_rsp)
   );

   assign rsp_tdata = {7'd0, rsp_bit};

endmodule

// ===== dv/led_matrix_text_scroll_scanner_checker.sv =====
`timescale 1ns / 100ps

module led_matrix_text_scroll_scanner_checker
   import lmts_pkg::*;
#(
   parameter int NUM_COLUMNS = 32,
   parameter int NUM_ROWS    = 8
)(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,   // char_code[7:0]
   input  logic [1:0] req_tuser,   // cmd[1:0]
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,   // serial_bit[0], zero fill [7:1]
   input  logic       rsp_tlast,
   input  logic       csr_wr_en,
   input  logic [5:0] csr_wr_data,
   output int         mismatch_count,
   output int         bits_pending
);

   localparam int CHAR_FIRST      = 32;
   localparam int CHAR_LAST       = 125;
   localparam int CHAR_COLUMNS    = 6;
   localparam int WRITE_POS_LIMIT = 63;

   // five lit columns per code, leftmost in the top byte
   localparam logic [39:0] GLYPH_TABLE [0:CHAR_LAST-CHAR_FIRST] = '{
      40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
      40'h24_2A_7F_2A_12, 40'h23_13_08_64_62, 40'h36_49_55_22_50, 40'h00_05_03_00_00,
      40'h00_1C_22_41_00, 40'h00_41_22_1C_00, 40'h14_08_3E_08_14, 40'h08_08_3E_08_08,
      40'h00_50_30_00_00, 40'h08_08_08_08_08, 40'h00_60_60_00_00, 40'h20_10_08_04_02,
      40'h3E_41_41_41_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31,
      40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
      40'h36_49_49_49_36, 40'h06_49_49_29_1E, 40'h00_36_36_00_00, 40'h00_56_36_00_00,
      40'h08_14_22_41_00, 40'h14_14_14_14_14, 40'h00_41_22_14_08, 40'h02_01_51_09_06,
      40'h32_49_79_41_3E, 40'h7E_09_09_09_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
      40'h7F_41_41_22_1C, 40'h7F_49_49_49_41, 40'h7F_09_09_09_01, 40'h3E_41_49_49_7A,
      40'h7F_08_08_08_7F, 40'h41_41_7F_41_41, 40'h20_40_40_40_3F, 40'h7F_08_14_22_41,
      40'h7F_40_40_40_40, 40'h7F_02_0C_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
      40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h46_49_49_49_31,
      40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h3F_40_38_40_3F,
      40'h63_14_08_14_63, 40'h07_08_70_08_07, 40'h61_51_49_45_43, 40'h00_7F_41_41_00,
      40'h02_04_08_10_20, 40'h00_41_41_7F_00, 40'h04_02_01_02_04, 40'h40_40_40_40_40,
      40'h00_01_02_04_00, 40'h20_54_54_54_78, 40'h7F_48_44_44_38, 40'h38_44_44_44_00,
      40'h38_44_44_48_7F, 40'h38_54_54_54_18, 40'h08_7E_09_01_02, 40'h08_14_54_54_3C,
      40'h7F_08_04_04_78, 40'h00_44_7D_40_00, 40'h20_40_44_3D_00, 40'h00_7F_10_28_44,
      40'h00_41_7F_40_00, 40'h7C_04_18_04_78, 40'h7C_08_04_04_78, 40'h38_44_44_44_38,
      40'h7C_14_14_14_08, 40'h08_14_14_18_7C, 40'h7C_08_04_04_08, 40'h48_54_54_54_20,
      40'h04_3F_44_40_20, 40'h3C_40_40_20_7C, 40'h1C_20_40_20_1C, 40'h3C_40_30_40_3C,
      40'h44_28_10_28_44, 40'h0C_50_50_50_3C, 40'h44_64_54_4C_44, 40'h00_08_36_41_00,
      40'h00_00_7F_00_00, 40'h00_41_36_08_00
   };

   typedef struct packed {
      logic serial_bit;
      logic latch_last;
   } scan_bit_type;

   logic [7:0]   columns [NUM_COLUMNS];
   logic [2:0]   row_sel;
   logic [6:0]   write_pos;
   logic [5:0]   active_reg;
   scan_bit_type scan_bits_q [$];
   int           mismatches;

   function automatic int active_width();
      int w;
      w = active_reg;
      if (w < 1) w = 1;
      if (w > NUM_COLUMNS) w = NUM_COLUMNS;
      return w;
   endfunction

   function automatic logic [7:0] glyph_column(logic [7:0] code, int k);
      logic [39:0] word;
      if (code < CHAR_FIRST || code > CHAR_LAST || k >= 5) return 8'd0;
      word = GLYPH_TABLE[code - CHAR_FIRST];
      return word[8*(4-k) +: 8];
   endfunction

   task automatic clear_columns();
      for (int i = 0; i < NUM_COLUMNS; i++) columns[i] = 8'd0;
      write_pos = 7'd0;
   endtask

   task automatic draw_char(logic [7:0] code);
      int width;
      width = active_width();
      for (int k = 0; k < CHAR_COLUMNS; k++)
         if (write_pos + k < width) columns[write_pos + k] = glyph_column(code, k);
      if (write_pos + CHAR_COLUMNS > WRITE_POS_LIMIT) write_pos = WRITE_POS_LIMIT;
      else write_pos = write_pos + CHAR_COLUMNS;
   endtask

   task automatic rotate_left();
      int         width;
      logic [7:0] first;
      width = active_width();
      first = columns[0];
      for (int i = 0; i + 1 < width; i++) columns[i] = columns[i + 1];
      columns[width - 1] = first;
   endtask

   task automatic queue_scan_row();
      scan_bit_type b;
      row_sel = 3'((row_sel + 1) % NUM_ROWS);
      for (int c = NUM_COLUMNS - 1; c >= 0; c--) begin
         b.serial_bit = columns[c][row_sel];
         b.latch_last = 1'b0;
         scan_bits_q.push_back(b);
      end
      for (int i = 0; i < 8; i++) begin
         b.serial_bit = (i == row_sel);
         b.latch_last = (i == 7);
         scan_bits_q.push_back(b);
      end
   endtask

   task automatic flag_mismatch(string what, int want_v, int got_v);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %0s: expected %0d, got %0d at %0t", what, want_v, got_v, $time);
   endtask

   always @(posedge clock) begin
      scan_bit_type want;
      if (reset) begin
         clear_columns();
         row_sel    = 3'd0;
         active_reg = ACTIVE_RESET;
         scan_bits_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (scan_bits_q.size() == 0) begin
               flag_mismatch("result item with none pending, tdata", -1, rsp_tdata);
            end else begin
               want = scan_bits_q.pop_front();
               if (rsp_tdata !== {7'd0, want.serial_bit})
                  flag_mismatch("serial_bit (tdata)", want.serial_bit, rsp_tdata);
               if (rsp_tlast !== want.latch_last)
                  flag_mismatch("latch_last (tlast)", want.latch_last, rsp_tlast);
            end
         end
         if (csr_wr_en) active_reg = csr_wr_data;
         if (req_tvalid && req_tready) begin
            case (cmd_type'(req_tuser))
               CMD_CLEAR:  clear_columns();
               CMD_PUT:    draw_char(req_tdata);
               CMD_SCROLL: rotate_left();
               CMD_SCAN:   queue_scan_row();
            endcase
         end
      end
      bits_pending   <= scan_bits_q.size();
      mismatch_count <= mismatches;
   end

endmodule

// ===== dv/tb_led_matrix_text_scroll_scanner_top.sv =====
`timescale 1ns / 100ps

module tb_led_matrix_text_scroll_scanner_top
   import lmts_pkg::*;
();

   localparam int NUM_COLUMNS    = 32;
   localparam int NUM_ROWS       = 8;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 100;
   localparam int BLOCK_ITEMS    = 32;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic [1:0] req_tuser;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic       csr_wr_en;
   logic [5:0] csr_wr_data;

   int mismatch_count;
   int bits_pending;
   int send_gap_pct;
   int stall_pct;
   int quiet_cycles;

   led_matrix_text_scroll_scanner_top #(
      .NUM_COLUMNS(NUM_COLUMNS),
      .NUM_ROWS   (NUM_ROWS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   led_matrix_text_scroll_scanner_checker #(
      .NUM_COLUMNS(NUM_COLUMNS),
      .NUM_ROWS   (NUM_ROWS)
   ) scan_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .mismatch_count(mismatch_count),
      .bits_pending  (bits_pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready = ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic write_active(logic [5:0] width);
      csr_wr_en   = 1'b1;
      csr_wr_data = width;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   // returns at the falling edge after acceptance, tvalid still high
   task automatic send_item(cmd_type cmd, logic [7:0] code);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = code;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_random();
      int         roll;
      logic [7:0] code;
      roll = $urandom_range(99);
      code = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(125, 32));
      if (roll < 8)       send_item(CMD_CLEAR, 8'($urandom));
      else if (roll < 45) send_item(CMD_PUT, code);
      else if (roll < 68) send_item(CMD_SCROLL, 8'($urandom));
      else                send_item(CMD_SCAN, 8'($urandom));
   endtask

   // sender holds off until the last scan bit is out and the sequencer has settled
   task automatic drain_scan_bits();
      req_tvalid = 1'b0;
      do @(posedge clock); while (bits_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      logic [5:0] widths [8];
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = 8'd0;
      req_tuser    = CMD_CLEAR;
      csr_wr_en    = 1'b0;
      csr_wr_data  = 6'd0;
      send_gap_pct = 0;
      stall_pct    = 0;
      widths       = '{6'd1, 6'd0, 6'd63, 6'd6, 6'd33, 6'd7, 6'd32, 6'd0};
      widths[7]    = 6'($urandom_range(31, 2));
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_active(6'd32);
      send_item(CMD_SCAN, 8'd0);
      send_item(CMD_PUT, 8'd72);
      send_item(CMD_PUT, 8'd32);
      send_item(CMD_PUT, 8'd125);
      send_item(CMD_PUT, 8'd33);
      send_item(CMD_PUT, 8'd126);
      send_item(CMD_PUT, 8'd31);
      send_item(CMD_PUT, 8'd0);
      send_item(CMD_PUT, 8'd255);
      send_item(CMD_SCAN, 8'd255);
      send_item(CMD_SCROLL, 8'd0);
      send_item(CMD_SCAN, 8'd0);
      // write position runs past the width and then saturates
      send_item(CMD_PUT, 8'd65);
      send_item(CMD_PUT, 8'd66);
      send_item(CMD_PUT, 8'd67);
      send_item(CMD_PUT, 8'd68);
      repeat (6) send_item(CMD_SCAN, 8'd0);
      send_item(CMD_CLEAR, 8'd0);
      send_item(CMD_SCAN, 8'd0);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 56; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 56; end
            default: begin send_gap_pct = 16; stall_pct = 16; end
         endcase
         for (int blk = 0; blk < 2; blk++) begin
            drain_scan_bits();
            write_active(widths[phase * 2 + blk]);
            send_item(CMD_CLEAR, 8'd0);
            repeat (BLOCK_ITEMS - 1) send_random();
         end
      end

      drain_scan_bits();
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
